// File: rtl/roller_shutter_motor_sequencer_core_macros.svh
// Assertion macros shared by the sequencer RTL.
// Each macro samples on the rising edge of clk and is held off while rst_n is low.
`ifndef ROLLER_SHUTTER_MOTOR_SEQUENCER_CORE_MACROS_SVH
`define ROLLER_SHUTTER_MOTOR_SEQUENCER_CORE_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define RSM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition holds at any edge where the enabling expression is true.
`define RSM_ASSERT_IMPL(label, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

`endif

// File: rtl/rsm_pkg.sv
`default_nettype none

package rsm_pkg;

    // Full travel in percent steps; position 0 is fully up.
    localparam int FULL_TRAVEL_DEFAULT = 100;

    localparam int POS_W   = 7;
    localparam int TICK_W  = 16;
    localparam int CFG_A_W = 3;
    localparam int CFG_D_W = 16;

    // Reset values of the configuration registers.
    localparam logic [TICK_W-1:0] STEP_TICKS_RESET       = 16'd100;
    localparam logic [TICK_W-1:0] OVERTRAVEL_TICKS_RESET = 16'd1000;
    localparam logic              DRIVE_LEVEL_RESET      = 1'b1;

    typedef enum logic [2:0] {
        ST_DOWN      = 3'd0,
        ST_DOWN_X    = 3'd1,
        ST_MV_DOWN   = 3'd2,
        ST_STOPPED   = 3'd3,
        ST_MV_UP     = 3'd4,
        ST_UP_X      = 3'd5,
        ST_UP        = 3'd6
    } state_t;

    typedef enum logic [2:0] {
        OP_TICK = 3'd0,
        OP_DOWN = 3'd1,
        OP_UP   = 3'd2,
        OP_HALT = 3'd3,
        OP_GOTO = 3'd4
    } opcode_t;

    typedef enum logic [CFG_A_W-1:0] {
        CFG_STEP_TICKS_DOWN       = 3'd0,
        CFG_STEP_TICKS_UP         = 3'd1,
        CFG_OVERTRAVEL_TICKS_DOWN = 3'd2,
        CFG_OVERTRAVEL_TICKS_UP   = 3'd3,
        CFG_DRIVE_ACTIVE_LEVEL    = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]       opcode;
        logic [POS_W-1:0] target_position;
    } rsm_in_t;

    typedef struct packed {
        logic             drive_open;
        logic             drive_close;
        logic [2:0]       machine_state;
        logic [POS_W-1:0] position;
        logic             state_changed;
        logic             position_report;
    } rsm_out_t;

    // Result of a command lookup: whether the state defines a move, and where to.
    typedef struct packed {
        logic   hit;
        state_t target;
    } trans_t;

    function automatic trans_t next_on_down(input state_t s);
        trans_t t;
        t.hit    = 1'b1;
        t.target = ST_MV_DOWN;
        unique case (s)
            ST_DOWN:                t.target = ST_DOWN_X;
            ST_DOWN_X, ST_MV_DOWN:  t.hit    = 1'b0;
            default:                t.target = ST_MV_DOWN;
        endcase
        return t;
    endfunction

    function automatic trans_t next_on_up(input state_t s);
        trans_t t;
        t.hit    = 1'b1;
        t.target = ST_MV_UP;
        unique case (s)
            ST_UP:              t.target = ST_UP_X;
            ST_MV_UP, ST_UP_X:  t.hit    = 1'b0;
            default:            t.target = ST_MV_UP;
        endcase
        return t;
    endfunction

    function automatic trans_t next_on_halt(input state_t s);
        trans_t t;
        t.hit    = 1'b1;
        t.target = ST_STOPPED;
        unique case (s)
            ST_DOWN_X:              t.target = ST_DOWN;
            ST_MV_DOWN, ST_MV_UP:   t.target = ST_STOPPED;
            ST_UP_X:                t.target = ST_UP;
            default:                t.hit    = 1'b0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// File: rtl/roller_shutter_motor_sequencer_core.sv
`default_nettype none

// Roller shutter motor sequencer.
// Input channel (in_valid / in_stall / in_item) carries one item per handshake: a tick
// or a command (down, up, halt, go to position). Output channel (out_valid / out_stall /
// out_item) returns exactly one result item per input item, in order, with the relay
// levels, the machine state, the estimated position and the two report flags.
// An accepted item lands in an input register; when the update stage advances, the
// machine state is updated and the result is written to the output register. One
// item per cycle is sustained: the single update stage and the output register both
// turn over every cycle while out_stall is low.
// When the receiver stalls, the result holds in the output register, the input
// register keeps one more item, and in_stall rises only once both are occupied.
// Reset (rst_n low, asynchronous) empties both registers, puts the machine in the
// stopped state at position 0 with step counting off and both timers at zero, and
// loads the configuration defaults: 100 ticks per step, 1000 overtravel ticks, and
// an active-high relay level. Configuration writes (cfg_wr_en, cfg_addr, cfg_wdata)
// take effect at once and are expected only while no item is in flight.
module roller_shutter_motor_sequencer_core #(
    parameter int FULL_TRAVEL = rsm_pkg::FULL_TRAVEL_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire rsm_pkg::rsm_in_t              in_item,
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output rsm_pkg::rsm_out_t                  out_item,
    input  wire logic                          cfg_wr_en,
    input  wire logic [rsm_pkg::CFG_A_W-1:0]   cfg_addr,
    input  wire logic [rsm_pkg::CFG_D_W-1:0]   cfg_wdata
);

    import rsm_pkg::*;

    localparam logic [POS_W-1:0] FULL_POS = POS_W'(FULL_TRAVEL);

    // Configuration registers.
    logic [TICK_W-1:0] step_down_reg;
    logic [TICK_W-1:0] step_up_reg;
    logic [TICK_W-1:0] ot_down_reg;
    logic [TICK_W-1:0] ot_up_reg;
    logic              level_reg;

    // Input register and output register of the single update stage.
    logic     in_valid_reg;
    rsm_in_t  in_item_reg;
    logic     out_valid_reg;
    rsm_out_t out_item_reg;

    // Machine state.
    state_t            state_reg, state_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  rem_reg, rem_next;
    logic              active_reg, active_next;
    logic [TICK_W-1:0] step_tmr_reg, step_tmr_next;
    logic [TICK_W-1:0] ot_tmr_reg, ot_tmr_next;

    logic     advance;
    logic     process;
    logic     changed_next;
    logic     report_next;
    rsm_out_t out_item_next;

    // The update stage moves whenever the output register is empty or being drained.
    assign advance   = !out_valid_reg || !out_stall;
    assign process   = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_down_reg <= STEP_TICKS_RESET;
            step_up_reg   <= STEP_TICKS_RESET;
            ot_down_reg   <= OVERTRAVEL_TICKS_RESET;
            ot_up_reg     <= OVERTRAVEL_TICKS_RESET;
            level_reg     <= DRIVE_LEVEL_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_STEP_TICKS_DOWN:       step_down_reg <= cfg_wdata;
                CFG_STEP_TICKS_UP:         step_up_reg   <= cfg_wdata;
                CFG_OVERTRAVEL_TICKS_DOWN: ot_down_reg   <= cfg_wdata;
                CFG_OVERTRAVEL_TICKS_UP:   ot_up_reg     <= cfg_wdata;
                CFG_DRIVE_ACTIVE_LEVEL:    level_reg     <= cfg_wdata[0];
                default:
                begin
                end
            endcase
        end
    end

    // Next machine state: at most one state entry per item. The first half works
    // out which entry (if any) the item causes and what it does to the count and
    // the timers beforehand; the second half applies the entry effects.
    always_comb
    begin
        trans_t           tr;
        logic [POS_W-1:0] tgt;
        logic             moving;

        tr            = '{hit: 1'b0, target: ST_STOPPED};
        tgt           = in_item_reg.target_position;
        moving        = (state_reg == ST_MV_DOWN) || (state_reg == ST_MV_UP);
        state_next    = state_reg;
        pos_next      = pos_reg;
        rem_next      = rem_reg;
        active_next   = active_reg;
        step_tmr_next = step_tmr_reg;
        ot_tmr_next   = ot_tmr_reg;
        changed_next  = 1'b0;
        report_next   = 1'b0;

        unique case (in_item_reg.opcode)
            OP_TICK:
            begin
                if (moving)
                begin
                    if (pos_reg == '0 || pos_reg == FULL_POS)
                    begin
                        tr.hit    = 1'b1;
                        tr.target = (state_reg == ST_MV_DOWN) ? ST_DOWN_X : ST_UP_X;
                    end
                    else if (active_reg && rem_reg == '0)
                    begin
                        tr.hit    = 1'b1;
                        tr.target = ST_STOPPED;
                    end
                    else if (step_tmr_reg <= TICK_W'(1))
                    begin
                        step_tmr_next = '0;
                        tr.hit        = 1'b1;
                        tr.target     = state_reg;
                    end
                    else
                    begin
                        step_tmr_next = step_tmr_reg - TICK_W'(1);
                    end
                end
                else if (state_reg == ST_DOWN_X || state_reg == ST_UP_X)
                begin
                    if (ot_tmr_reg <= TICK_W'(1))
                    begin
                        ot_tmr_next = '0;
                        tr.hit      = 1'b1;
                        tr.target   = (state_reg == ST_DOWN_X) ? ST_DOWN : ST_UP;
                    end
                    else
                    begin
                        ot_tmr_next = ot_tmr_reg - TICK_W'(1);
                    end
                end
            end
            OP_DOWN:
            begin
                active_next = 1'b0;
                tr          = next_on_down(state_reg);
            end
            OP_UP:
            begin
                active_next = 1'b0;
                tr          = next_on_up(state_reg);
            end
            OP_HALT:
            begin
                active_next = 1'b0;
                tr          = next_on_halt(state_reg);
            end
            OP_GOTO:
            begin
                // The ends never count as reached, so a target at either end always issues its command.
                if (tgt > pos_reg || tgt == FULL_POS)
                begin
                    rem_next    = tgt - pos_reg;
                    active_next = 1'b1;
                    tr          = next_on_down(state_reg);
                end
                else if (tgt < pos_reg || tgt == '0)
                begin
                    rem_next    = pos_reg - tgt;
                    active_next = 1'b1;
                    tr          = next_on_up(state_reg);
                end
            end
            default:
            begin
            end
        endcase

        if (tr.hit)
        begin
            state_next   = tr.target;
            changed_next = 1'b1;
            unique case (tr.target)
                ST_DOWN_X:
                    ot_tmr_next = ot_down_reg;
                ST_MV_DOWN:
                begin
                    step_tmr_next = step_down_reg;
                    if (active_next && rem_next != '0)
                        rem_next = rem_next - POS_W'(1);
                    if (pos_reg < FULL_POS)
                        pos_next = pos_reg + POS_W'(1);
                    report_next = !pos_next[0];
                end
                ST_STOPPED:
                    report_next = 1'b1;
                ST_MV_UP:
                begin
                    step_tmr_next = step_up_reg;
                    if (active_next && rem_next != '0)
                        rem_next = rem_next - POS_W'(1);
                    if (pos_reg != '0)
                        pos_next = pos_reg - POS_W'(1);
                    report_next = !pos_next[0];
                end
                ST_UP_X:
                    ot_tmr_next = ot_up_reg;
                default:
                begin
                end
            endcase
        end
    end

    // Result item: relay levels follow the state just reached.
    always_comb
    begin
        logic drive_up;
        logic drive_down;

        drive_up   = (state_next == ST_MV_UP) || (state_next == ST_UP_X);
        drive_down = (state_next == ST_MV_DOWN) || (state_next == ST_DOWN_X);
        out_item_next.drive_open      = drive_up ? level_reg : !level_reg;
        out_item_next.drive_close     = drive_down ? level_reg : !level_reg;
        out_item_next.machine_state   = state_next;
        out_item_next.position        = pos_next;
        out_item_next.state_changed   = changed_next;
        out_item_next.position_report = report_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= ST_STOPPED;
            pos_reg       <= '0;
            rem_reg       <= '0;
            active_reg    <= 1'b0;
            step_tmr_reg  <= '0;
            ot_tmr_reg    <= '0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= in_valid_reg;
            if (process)
            begin
                state_reg    <= state_next;
                pos_reg      <= pos_next;
                rem_reg      <= rem_next;
                active_reg   <= active_next;
                step_tmr_reg <= step_tmr_next;
                ot_tmr_reg   <= ot_tmr_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            in_item_reg <= in_item;
        if (process)
            out_item_reg <= out_item_next;
    end

`include "roller_shutter_motor_sequencer_core_macros.svh"

    `RSM_ASSERT(a_pos_in_range, pos_reg <= FULL_POS, "position left the travel range")
    `RSM_ASSERT_IMPL(a_relays_exclusive, out_valid_reg,
        !(out_item_reg.drive_open == level_reg && out_item_reg.drive_close == level_reg),
        "both relays driven active")
    `RSM_ASSERT_IMPL(a_stop_reports, out_valid_reg && out_item_reg.state_changed &&
        out_item_reg.machine_state == ST_STOPPED, out_item_reg.position_report,
        "entry to stopped without a position report")
    `RSM_ASSERT(a_change_flagged,
        (process && state_next != state_reg) |=> out_item_reg.state_changed,
        "state moved without the changed flag")

endmodule

`default_nettype wire
